### design/tkp_pkg.sv
// Shared constants, types and codes for the top-k peak picker.
package tkp_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_POINTS = 16;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int TOTAL_W = ADDR_W + 1;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int NPTS_W  = 5;
  localparam int RAD_W   = 8;
  localparam int CFG_W   = 9;
  localparam int PICK_W  = $clog2(MAX_POINTS);

  localparam logic [DIM_W-1:0]  RST_WIDTH   = DIM_W'(256);
  localparam logic [DIM_W-1:0]  RST_HEIGHT  = DIM_W'(256);
  localparam logic [NPTS_W-1:0] RST_NPOINTS = NPTS_W'(4);
  localparam logic [RAD_W-1:0]  RST_RADIUS  = RAD_W'(32);

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_NUM_POINTS      = 2'd2,
    CFG_SUPPRESS_RADIUS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_CORNER,
    ST_BASE,
    ST_ZERO
  } state_e;

  // Register values, already clamped to their legal ranges.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [NPTS_W-1:0] npoints;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

  // Tag that travels alongside a pixel read from the store.
  typedef struct packed {
    logic               vld;
    logic               first;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } sample_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } peak_t;

endpackage

### design/tkp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### design/tkp_cfg.sv
// Configuration registers, clamped to their legal ranges on write.
module tkp_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  tkp_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [tkp_pkg::CFG_W-1:0] cfg_wdata_i,
  output tkp_pkg::cfg_t            cfg_o
);
  import tkp_pkg::*;

  cfg_t cfg_q, cfg_d;

  logic [DIM_W-1:0]  dim_v;
  logic [NPTS_W-1:0] npts_v;
  logic [RAD_W-1:0]  rad_v;
  logic [DIM_W-1:0]  width_c, height_c;
  logic [NPTS_W-1:0] npts_c;
  logic [RAD_W-1:0]  rad_c;

  always_comb begin
    dim_v  = cfg_wdata_i[DIM_W-1:0];
    npts_v = cfg_wdata_i[NPTS_W-1:0];
    rad_v  = cfg_wdata_i[RAD_W-1:0];

    if (dim_v == '0) begin
      width_c = DIM_W'(1);
    end else if (dim_v > DIM_W'(MAX_WIDTH)) begin
      width_c = DIM_W'(MAX_WIDTH);
    end else begin
      width_c = dim_v;
    end

    if (dim_v == '0) begin
      height_c = DIM_W'(1);
    end else if (dim_v > DIM_W'(MAX_HEIGHT)) begin
      height_c = DIM_W'(MAX_HEIGHT);
    end else begin
      height_c = dim_v;
    end

    if (npts_v == '0) begin
      npts_c = NPTS_W'(1);
    end else if (npts_v > NPTS_W'(MAX_POINTS)) begin
      npts_c = NPTS_W'(MAX_POINTS);
    end else begin
      npts_c = npts_v;
    end

    rad_c = (rad_v == '0) ? RAD_W'(1) : rad_v;
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:     cfg_d.width   = width_c;
        CFG_FRAME_HEIGHT:    cfg_d.height  = height_c;
        CFG_NUM_POINTS:      cfg_d.npoints = npts_c;
        CFG_SUPPRESS_RADIUS: cfg_d.radius  = rad_c;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= RST_WIDTH;
      cfg_q.height  <= RST_HEIGHT;
      cfg_q.npoints <= RST_NPOINTS;
      cfg_q.radius  <= RST_RADIUS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/tkp_argmax.sv
// Running maximum over the pixels streamed out of the store; first wins on ties.
module tkp_argmax (
  input  logic                      clk_i,
  input  tkp_pkg::sample_t          sample_i,
  input  logic [tkp_pkg::PIX_W-1:0] rdata_i,
  output tkp_pkg::peak_t            best_o
);
  import tkp_pkg::*;

  logic [PIX_W-1:0] best_val_q, best_val_d;
  peak_t            best_q, best_d;
  logic             take;

  assign take = sample_i.vld && (sample_i.first || (rdata_i > best_val_q));

  always_comb begin
    best_val_d = best_val_q;
    best_d     = best_q;
    if (take) begin
      best_val_d = rdata_i;
      best_d.x   = sample_i.x;
      best_d.y   = sample_i.y;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
    best_q     <= best_d;
  end

  assign best_o = best_q;

endmodule

### design/tkp_seq.sv
// Sequencer: frame load, store scans, peak emit and square zeroing.
module tkp_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tkp_pkg::PIX_W-1:0]  pixel_value_i,
  input  tkp_pkg::cfg_t              cfg_i,
  input  tkp_pkg::peak_t             best_i,
  output logic                       busy_o,
  output logic                       ram_we_o,
  output logic [tkp_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [tkp_pkg::PIX_W-1:0]  ram_wdata_o,
  output logic                       ram_re_o,
  output logic [tkp_pkg::ADDR_W-1:0] ram_raddr_o,
  output tkp_pkg::sample_t           sample_o,
  output logic                       peak_valid_o,
  output logic                       last_peak_o
);
  import tkp_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  load_cnt_q, load_cnt_d;
  logic [ADDR_W-1:0]  scan_addr_q, scan_addr_d;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  sample_t            sample_q, sample_d;
  logic [PICK_W-1:0]  pick_q, pick_d;

  logic [COORD_W-1:0] tlx_q, tlx_d, tly_q, tly_d;
  logic [DIM_W-1:0]   ex_q, ex_d, ey_q, ey_d;
  logic [DIM_W-1:0]   zcol_q, zcol_d, zrow_q, zrow_d;
  logic [ADDR_W-1:0]  row_base_q, row_base_d, zaddr_q, zaddr_d;

  logic [TOTAL_W-1:0]       total;
  logic                     accept;
  logic                     frame_done;
  logic                     scan_last;
  logic                     col_wrap;
  logic                     last_pick;
  logic [COORD_W-1:0]       tlx_c, tly_c;
  logic [DIM_W-1:0]         side, wrem, hrem, ex_c, ey_c;
  logic [COORD_W+DIM_W-1:0] base_prod;
  logic [ADDR_W-1:0]        base_c, next_base;
  logic                     zcol_end, zrow_end;

  assign total      = TOTAL_W'(cfg_i.width) * TOTAL_W'(cfg_i.height);
  assign accept     = start_i && (state_q == ST_LOAD);
  assign frame_done = (TOTAL_W'(load_cnt_q) + TOTAL_W'(1)) >= total;
  assign scan_last  = TOTAL_W'(scan_addr_q) == (total - TOTAL_W'(1));
  assign col_wrap   = col_q == COORD_W'(cfg_i.width - DIM_W'(1));
  assign last_pick  = (NPTS_W'(pick_q) + NPTS_W'(1)) == cfg_i.npoints;

  // Suppression square: corner clamped at zero, extent cut at the frame edge.
  assign tlx_c = (best_i.x > cfg_i.radius) ? best_i.x - cfg_i.radius : '0;
  assign tly_c = (best_i.y > cfg_i.radius) ? best_i.y - cfg_i.radius : '0;
  assign side  = {cfg_i.radius, 1'b1};
  assign wrem  = cfg_i.width - DIM_W'(tlx_c);
  assign hrem  = cfg_i.height - DIM_W'(tly_c);
  assign ex_c  = (wrem < side) ? wrem : side;
  assign ey_c  = (hrem < side) ? hrem : side;

  assign base_prod = (COORD_W+DIM_W)'(tly_q) * (COORD_W+DIM_W)'(cfg_i.width);
  assign base_c    = ADDR_W'(base_prod) + ADDR_W'(tlx_q);
  assign next_base = row_base_q + ADDR_W'(cfg_i.width);
  assign zcol_end  = zcol_q == (ex_q - DIM_W'(1));
  assign zrow_end  = zrow_q == (ey_q - DIM_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:   if (accept && frame_done) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_CORNER;
      ST_CORNER: state_d = last_pick ? ST_LOAD : ST_BASE;
      ST_BASE:   state_d = ST_ZERO;
      ST_ZERO:   if (zcol_end && zrow_end) state_d = ST_SCAN;
      default:   state_d = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o       = 1'b1;
    ram_we_o     = 1'b0;
    ram_waddr_o  = zaddr_q;
    ram_wdata_o  = '0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = scan_addr_q;
    peak_valid_o = 1'b0;
    last_peak_o  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        busy_o      = 1'b0;
        ram_we_o    = accept;
        ram_waddr_o = load_cnt_q;
        ram_wdata_o = pixel_value_i;
      end
      ST_SCAN:   ram_re_o = 1'b1;
      ST_CORNER: begin
        peak_valid_o = 1'b1;
        last_peak_o  = last_pick;
      end
      ST_ZERO:   ram_we_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

  // Datapath next values
  always_comb begin
    load_cnt_d  = load_cnt_q;
    scan_addr_d = '0;
    col_d       = '0;
    row_d       = '0;
    pick_d      = pick_q;
    tlx_d       = tlx_q;
    tly_d       = tly_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    zcol_d      = zcol_q;
    zrow_d      = zrow_q;
    row_base_d  = row_base_q;
    zaddr_d     = zaddr_q;

    sample_d.vld   = (state_q == ST_SCAN);
    sample_d.first = (scan_addr_q == '0);
    sample_d.x     = col_q;
    sample_d.y     = row_q;

    if (accept) begin
      load_cnt_d = frame_done ? '0 : load_cnt_q + ADDR_W'(1);
    end

    case (state_q)
      ST_SCAN: begin
        scan_addr_d = scan_addr_q + ADDR_W'(1);
        col_d       = col_wrap ? '0 : col_q + COORD_W'(1);
        row_d       = col_wrap ? row_q + COORD_W'(1) : row_q;
      end
      ST_CORNER: begin
        pick_d = last_pick ? '0 : pick_q + PICK_W'(1);
        tlx_d  = tlx_c;
        tly_d  = tly_c;
        ex_d   = ex_c;
        ey_d   = ey_c;
      end
      ST_BASE: begin
        row_base_d = base_c;
        zaddr_d    = base_c;
        zcol_d     = '0;
        zrow_d     = '0;
      end
      ST_ZERO: begin
        if (zcol_end) begin
          zcol_d     = '0;
          zrow_d     = zrow_q + DIM_W'(1);
          row_base_d = next_base;
          zaddr_d    = next_base;
        end else begin
          zcol_d  = zcol_q + DIM_W'(1);
          zaddr_d = zaddr_q + ADDR_W'(1);
        end
      end
      default: begin
        pick_d = pick_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      scan_addr_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pick_q      <= '0;
      sample_q    <= '0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      scan_addr_q <= scan_addr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pick_q      <= pick_d;
      sample_q    <= sample_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tlx_q      <= tlx_d;
    tly_q      <= tly_d;
    ex_q       <= ex_d;
    ey_q       <= ey_d;
    zcol_q     <= zcol_d;
    zrow_q     <= zrow_d;
    row_base_q <= row_base_d;
    zaddr_q    <= zaddr_d;
  end

  assign sample_o = sample_q;

endmodule

### design/top_k_peak_picker.sv
// Top level of the top-k peak picker: config, sequencer, pixel store, argmax unit.
//
// Usage: write frame_width, frame_height, num_points and suppress_radius through
// the cfg_we_i / cfg_idx_i / cfg_wdata_i port while the block is idle. Then send
// a frame in raster order, one pixel per request (start high while busy is low).
// Pixels load at one per cycle and busy stays low until the last pixel of the
// frame is taken. From there busy is high while the picks run.
// Each pick scans the whole stored frame through the single read port of the
// pixel store and then, unless it is the final pick, zeroes the suppression
// square one pixel per cycle through the write port. A peak shows on peak_x_o /
// peak_y_o for one cycle with peak_valid_o high; last_peak_o marks the final
// one, and busy drops in the next cycle. The receiver cannot hold results off.
// Reset restores the register defaults (256, 256, 4, 32) and the load count; the
// pixel store is not cleared, since every entry is written before it is read.
module top_k_peak_picker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tkp_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic                         cfg_we_i,
  input  tkp_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [tkp_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                         peak_valid_o,
  output logic [tkp_pkg::COORD_W-1:0]  peak_x_o,
  output logic [tkp_pkg::COORD_W-1:0]  peak_y_o,
  output logic                         last_peak_o
);
  import tkp_pkg::*;

  cfg_t              cfg;
  peak_t             best;
  sample_t           sample;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  tkp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tkp_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .pixel_value_i (pixel_value_i),
    .cfg_i         (cfg),
    .best_i        (best),
    .busy_o        (busy),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .sample_o      (sample),
    .peak_valid_o  (peak_valid_o),
    .last_peak_o   (last_peak_o)
  );

  tkp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tkp_argmax u_argmax (
    .clk_i    (clk_i),
    .sample_i (sample),
    .rdata_i  (ram_rdata),
    .best_o   (best)
  );

  assign peak_x_o = best.x;
  assign peak_y_o = best.y;

endmodule

### design/tkp_checker.sv
// Port-level checks for the top-k peak picker, bound to the top level.
module tkp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         busy,
  input logic                         peak_valid_o,
  input logic [tkp_pkg::COORD_W-1:0]  peak_x_o,
  input logic [tkp_pkg::COORD_W-1:0]  peak_y_o,
  input logic                         last_peak_o
);

  // peaks only come out while the picks run
  a_peak_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_valid_o |-> busy)
    else $error("peak strobe while not busy");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_valid_o && last_peak_o |=> !busy)
    else $error("still busy after final peak");

  // zeroing and a rescan always separate two peaks
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_valid_o && !last_peak_o |=> !peak_valid_o)
    else $error("two peaks in consecutive cycles");

  a_busy_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(peak_valid_o && last_peak_o))
    else $error("busy dropped without a final peak");

  a_peak_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_valid_o |-> !$isunknown({peak_x_o, peak_y_o, last_peak_o}))
    else $error("peak fields unknown on strobe");

endmodule

bind top_k_peak_picker tkp_checker u_tkp_checker (.*);

### bench/top_k_peak_picker_test.sv
// Self-checking testbench for the top-k peak picker: random frames, configs and checked peaks.
module top_k_peak_picker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tkp_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               is_last;
  } peak_rec_t;

  // Shadow of the frame store and registers; predicts the peaks of each frame.
  class frame_peaks;
    logic [PIX_W-1:0]  frame_mem [DEPTH];
    int unsigned       pixels_loaded;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [NPTS_W-1:0] npoints_reg;
    logic [RAD_W-1:0]  radius_reg;
    peak_rec_t         pending_peaks [$];
    int unsigned       errors;
    int unsigned       peaks_seen;

    function new();
      pixels_loaded = 0;
      width_reg     = RST_WIDTH;
      height_reg    = RST_HEIGHT;
      npoints_reg   = RST_NPOINTS;
      radius_reg    = RST_RADIUS;
      errors        = 0;
      peaks_seen    = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:     width_reg   = data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:    height_reg  = data[DIM_W-1:0];
        CFG_NUM_POINTS:      npoints_reg = data[NPTS_W-1:0];
        CFG_SUPPRESS_RADIUS: radius_reg  = data[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_pixel(logic [PIX_W-1:0] v);
      int unsigned w, h, total, n, r, side, best, x, y, tlx, tly, ex, ey;
      int unsigned k, i, xx, yy;
      logic [PIX_W-1:0] best_val;
      peak_rec_t rec;
      w     = clip(width_reg, MAX_WIDTH);
      h     = clip(height_reg, MAX_HEIGHT);
      n     = clip(npoints_reg, MAX_POINTS);
      r     = clip(radius_reg, 255);
      total = w * h;
      side  = 2 * r + 1;
      frame_mem[pixels_loaded] = v;
      if (pixels_loaded + 1 < total) begin
        pixels_loaded++;
        return;
      end
      pixels_loaded = 0;
      for (k = 0; k < n; k++) begin
        best     = 0;
        best_val = frame_mem[0];
        // strict compare: ties keep the earliest raster position
        for (i = 1; i < total; i++) begin
          if (frame_mem[i] > best_val) begin
            best_val = frame_mem[i];
            best     = i;
          end
        end
        x   = best % w;
        y   = best / w;
        tlx = (x > r) ? x - r : 0;
        tly = (y > r) ? y - r : 0;
        ex  = (w - tlx < side) ? w - tlx : side;
        ey  = (h - tly < side) ? h - tly : side;
        for (yy = tly; yy < tly + ey; yy++)
          for (xx = tlx; xx < tlx + ex; xx++)
            frame_mem[yy * w + xx] = '0;
        rec.x       = x[COORD_W-1:0];
        rec.y       = y[COORD_W-1:0];
        rec.is_last = (k + 1 == n);
        pending_peaks = {pending_peaks, rec};
      end
    endfunction

    function void check_peak(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic is_last);
      peak_rec_t want;
      peaks_seen++;
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected peak x=%0d y=%0d last=%0b", $time, x, y, is_last);
        errors++;
        return;
      end
      want = pending_peaks.pop_front();
      if (x !== want.x) begin
        $display("%0t: peak_x expected %0d, actual %0d", $time, want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $display("%0t: peak_y expected %0d, actual %0d", $time, want.y, y);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: last_peak expected %0b, actual %0b", $time, want.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [PIX_W-1:0]   pixel_value_i;
  logic               cfg_we_i;
  cfg_idx_e           cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               peak_valid_o;
  logic [COORD_W-1:0] peak_x_o;
  logic [COORD_W-1:0] peak_y_o;
  logic               last_peak_o;

  frame_peaks  fp = new();
  bit          gaps_on;
  int unsigned random_items;
  int unsigned quiet_cycles;

  top_k_peak_picker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_value_i(pixel_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .peak_valid_o (peak_valid_o),
    .peak_x_o     (peak_x_o),
    .peak_y_o     (peak_y_o),
    .last_peak_o  (last_peak_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Sample everything at the rising edge; the watchdog counts edges with no traffic.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a pixel taken at this edge still sees the old registers
      if (start && !busy) fp.load_pixel(pixel_value_i);
      if (cfg_we_i) fp.set_reg(cfg_idx_i, cfg_wdata_i);
      if (peak_valid_o) fp.check_peak(peak_x_o, peak_y_o, last_peak_o);
      if (cfg_we_i || (start && !busy) || peak_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(99) < 8) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    pixel_value_i <= v;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (fp.pending_peaks.size() != 0 || busy) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_regs(input bit [3:0] sel, input logic [CFG_W-1:0] w,
                          input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] n,
                          input logic [CFG_W-1:0] r);
    cfg_idx_e         idx [4] = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT,
                                  CFG_NUM_POINTS, CFG_SUPPRESS_RADIUS};
    logic [CFG_W-1:0] vals [4];
    vals = '{w, h, n, r};
    for (int j = 0; j < 4; j++) begin
      if (sel[j]) begin
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= idx[j];
        cfg_wdata_i <= vals[j];
        @(negedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // mode 0: uniform, 1: few levels (many ties), 2: sparse bright spots
  task automatic send_frame(input int mode);
    int unsigned      npix, i;
    logic [PIX_W-1:0] v;
    npix = fp.clip(fp.width_reg, MAX_WIDTH) * fp.clip(fp.height_reg, MAX_HEIGHT);
    for (i = 0; i < npix; i++) begin
      case (mode)
        0:       v = PIX_W'($urandom_range(0, 255));
        1:       v = PIX_W'($urandom_range(0, 3));
        default: v = ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 255)) : 8'd0;
      endcase
      send_pixel(v);
      random_items++;
    end
  endtask

  initial begin
    int unsigned      frame_no;
    logic [CFG_W-1:0] w, h, n, r;
    start         = 1'b0;
    pixel_value_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FRAME_WIDTH;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    gaps_on       = 1'b1;
    random_items  = 0;
    quiet_cycles  = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero width and height act as 1x1; count and radius keep their reset values
    set_regs(4'b0011, 9'd0, 9'd0, 9'd0, 9'd0);
    send_pixel(8'hFF);
    wait_drained();

    // zero count and radius act as 1; brightest ties resolve to first in raster
    set_regs(4'b1111, 9'd3, 9'd3, 9'd0, 9'd0);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h07);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h80);
    send_pixel(8'h03); send_pixel(8'hFF); send_pixel(8'h01);
    wait_drained();

    // count saturates at 16; huge radius clears all, later picks land on (0,0)
    set_regs(4'b1111, 9'd4, 9'd2, 9'd31, 9'd255);
    send_pixel(8'h55); send_pixel(8'hAA); send_pixel(8'hAA); send_pixel(8'h00);
    send_pixel(8'hAA); send_pixel(8'h01); send_pixel(8'h55); send_pixel(8'hAA);
    wait_drained();

    frame_no = 0;
    do begin
      gaps_on = (frame_no != 2);
      if (frame_no == 2) begin
        // oversized width saturates to a full 256-pixel row
        wait_drained();
        set_regs(4'b1111, 9'h1FF, 9'd0, 9'd16, 9'd1);
      end else if (frame_no == 6) begin
        wait_drained();
        set_regs(4'b1111, 9'd0, 9'd6, 9'd16, 9'd128);
      end else if (frame_no == 0 || frame_no == 3 || $urandom_range(0, 2) == 0) begin
        wait_drained();
        w = CFG_W'($urandom_range(0, 8));
        h = CFG_W'($urandom_range(0, 8));
        n = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                        : CFG_W'($urandom_range(1, 8));
        case ($urandom_range(0, 3))
          0:       r = CFG_W'($urandom_range(0, 2));
          1:       r = CFG_W'($urandom_range(1, 4));
          2:       r = CFG_W'($urandom_range(0, 255));
          default: r = 9'd1;
        endcase
        set_regs((frame_no == 0 || frame_no == 3) ? 4'hF : 4'($urandom_range(1, 15)),
                 w, h, n, r);
      end
      send_frame($urandom_range(0, 2));
      frame_no++;
    end while (random_items < 360 || frame_no < 8 || fp.peaks_seen < 48);

    start <= 1'b0;
    while (fp.pending_peaks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fp.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
